// ===== src/sdc_pkg.sv =====
// sdc_pkg: shared types and constants of the sd card command sequencer
`default_nettype none

package sdc_pkg;

  // event codes on the input channel
  localparam logic [2:0] KIND_START     = 3'd0;
  localparam logic [2:0] KIND_RESP      = 3'd1;
  localparam logic [2:0] KIND_READ      = 3'd2;
  localparam logic [2:0] KIND_WRITE     = 3'd3;
  localparam logic [2:0] KIND_DATA_DONE = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_COND_TRIES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_COND_ARG   = 1'd1;

  localparam logic [7:0]  OP_COND_TRIES_RST = 8'd10;
  localparam logic [31:0] OP_COND_ARG_RST   = 32'h4001_8000;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
  localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA     = 6'd3;
  localparam logic [5:0] CMD_SELECT       = 6'd7;
  localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
  localparam logic [5:0] CMD_SEND_STATUS  = 6'd13;
  localparam logic [5:0] CMD_SET_BLKLEN   = 6'd16;
  localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
  localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
  localparam logic [5:0] ACMD_SD_OP_COND  = 6'd41;
  localparam logic [5:0] CMD_APP_CMD      = 6'd55;

  // command arguments
  localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
  localparam logic [31:0] BLKLEN_ARG  = 32'd512;

  // command register bits 15:6
  localparam logic [9:0] FL_RESP  = 10'h001;
  localparam logic [9:0] FL_LONG  = 10'h002;
  localparam logic [9:0] FL_CRC   = 10'h004;
  localparam logic [9:0] FL_DATA  = 10'h008;
  localparam logic [9:0] FL_WRITE = 10'h010;
  localparam logic [9:0] FL_WAIT  = 10'h080;
  localparam logic [9:0] FL_INIT  = 10'h200;

  // card status: current_state code for programming
  localparam logic [3:0] CARD_STATE_PRG = 4'd7;

  // csd structure versions
  localparam logic [1:0] CSD_V1 = 2'd0;
  localparam logic [1:0] CSD_V2 = 2'd1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD0   = 4'd1,
    PH_CMD8   = 4'd2,
    PH_CMD55  = 4'd3,
    PH_ACMD41 = 4'd4,
    PH_CMD2   = 4'd5,
    PH_CMD3   = 4'd6,
    PH_CMD9   = 4'd7,
    PH_CMD7   = 4'd8,
    PH_CMD16  = 4'd9,
    PH_READY  = 4'd10,
    PH_WDATA  = 4'd11,
    PH_STATUS = 4'd12
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  try_count;
    logic [15:0] card_address;
    logic [1:0]  csd_version;
    logic [31:0] card_capacity;
    logic        op_cond_failed;
    logic        no_card;
  } state_t;

  localparam state_t ST_RESET = '{PH_IDLE, 8'd0, 16'd0, 2'd0, 32'd0, 1'b0, 1'b0};

  typedef struct packed {
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [9:0]  cmd_flags;
    logic        cmd_valid;
    logic        init_done;
    logic [31:0] capacity_kb;
    logic        high_capacity;
    logic        no_card;
    logic        op_cond_failed;
  } result_t;

endpackage

`default_nettype wire

// ===== src/sdc_csd_decode.sv =====
// sdc_csd_decode: csd register decode into structure version and capacity in kilobytes
`default_nettype none

module sdc_csd_decode (
  input  wire logic [31:0] csd_word1,
  input  wire logic [31:0] csd_word2,
  input  wire logic [31:0] csd_word3,
  output logic      [1:0]  csd_version,
  output logic      [31:0] capacity_kb,
  output logic             unknown
);
  import sdc_pkg::*;

  logic [11:0] v1_c_size;
  logic [12:0] v1_blocks;
  logic [4:0]  v1_shift;
  logic [36:0] v1_bytes;
  logic [21:0] v2_c_size;
  logic [22:0] v2_units;

  // standard capacity: (c_size + 1) << (size_mult + 2 + read_bl_len) bytes
  assign v1_c_size = {csd_word2[9:0], csd_word1[31:30]};
  assign v1_blocks = {1'b0, v1_c_size} + 13'd1;
  assign v1_shift  = {2'b00, csd_word1[17:15]} + 5'd2 + {1'b0, csd_word2[19:16]};
  assign v1_bytes  = {24'd0, v1_blocks} << v1_shift;

  // high capacity: (c_size + 1) * 512 kilobytes
  assign v2_c_size = {csd_word2[5:0], csd_word1[31:16]};
  assign v2_units  = {1'b0, v2_c_size} + 23'd1;

  assign csd_version = csd_word3[31:30];

  always_comb begin
    unknown = 1'b0;
    unique case (csd_version)
      CSD_V1:  capacity_kb = {5'd0, v1_bytes[36:10]};
      CSD_V2:  capacity_kb = {v2_units[22:0], 9'd0};
      default: begin
        capacity_kb = 32'd0;
        unknown     = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/sdc_step.sv =====
// sdc_step: next sequencer state and result for one event
`default_nettype none

module sdc_step (
  input  wire  sdc_pkg::state_t  st,
  input  wire  logic [7:0]       op_cond_tries,
  input  wire  logic [31:0]      op_cond_argument,
  input  wire  logic [2:0]       kind,
  input  wire  logic [31:0]      resp_word0,
  input  wire  logic [31:0]      resp_word1,
  input  wire  logic [31:0]      resp_word2,
  input  wire  logic [31:0]      resp_word3,
  input  wire  logic [31:0]      sector,
  output sdc_pkg::state_t        st_nxt,
  output logic                   has_result,
  output sdc_pkg::result_t       res
);
  import sdc_pkg::*;

  logic [1:0]  csd_version;
  logic [31:0] csd_capacity;
  logic        csd_unknown;
  logic [31:0] rca_arg;
  logic [31:0] data_addr;
  logic [7:0]  try_inc;
  logic        cmd_valid;
  logic [5:0]  cmd_index;
  logic [31:0] cmd_arg;
  logic [9:0]  cmd_flags;
  logic        card_ready;

  sdc_csd_decode u_csd (
    .csd_word1   (resp_word1),
    .csd_word2   (resp_word2),
    .csd_word3   (resp_word3),
    .csd_version (csd_version),
    .capacity_kb (csd_capacity),
    .unknown     (csd_unknown)
  );

  assign rca_arg   = {st.card_address, 16'd0};
  // byte addressing for standard capacity cards, wraps at 4 GB
  assign data_addr = (st.csd_version == CSD_V1) ? {sector[22:0], 9'd0} : sector;
  assign try_inc   = st.try_count + 8'd1;
  assign card_ready = resp_word0[8] && (resp_word0[12:9] != CARD_STATE_PRG);

  always_comb begin
    st_nxt     = st;
    has_result = 1'b0;
    cmd_valid  = 1'b0;
    cmd_index  = CMD_GO_IDLE;
    cmd_arg    = 32'd0;
    cmd_flags  = 10'd0;
    unique case (kind)
      KIND_START: begin
        st_nxt       = ST_RESET;
        st_nxt.phase = PH_CMD0;
        has_result   = 1'b1;
        cmd_valid    = 1'b1;
        cmd_index    = CMD_GO_IDLE;
        cmd_flags    = FL_INIT | FL_CRC;
      end
      KIND_READ: begin
        if (st.phase == PH_READY) begin
          has_result = 1'b1;
          cmd_valid  = 1'b1;
          cmd_index  = CMD_READ_SINGLE;
          cmd_arg    = data_addr;
          cmd_flags  = FL_RESP | FL_CRC | FL_DATA | FL_WAIT;
        end
      end
      KIND_WRITE: begin
        if (st.phase == PH_READY) begin
          st_nxt.phase = PH_WDATA;
          has_result   = 1'b1;
          cmd_valid    = 1'b1;
          cmd_index    = CMD_WRITE_SINGLE;
          cmd_arg      = data_addr;
          cmd_flags    = FL_RESP | FL_CRC | FL_DATA | FL_WAIT | FL_WRITE;
        end
      end
      KIND_DATA_DONE: begin
        if (st.phase == PH_WDATA) begin
          st_nxt.phase = PH_STATUS;
          has_result   = 1'b1;
          cmd_valid    = 1'b1;
          cmd_index    = CMD_SEND_STATUS;
          cmd_arg      = rca_arg;
          cmd_flags    = FL_RESP | FL_CRC;
        end
      end
      KIND_RESP: begin
        unique case (st.phase)
          PH_CMD0: begin
            st_nxt.phase = PH_CMD8;
            has_result   = 1'b1;
            cmd_valid    = 1'b1;
            cmd_index    = CMD_SEND_IF_COND;
            cmd_arg      = IF_COND_ARG;
            cmd_flags    = FL_RESP | FL_CRC;
          end
          PH_CMD8: begin
            st_nxt.phase = PH_CMD55;
            has_result   = 1'b1;
            cmd_valid    = 1'b1;
            cmd_index    = CMD_APP_CMD;
            cmd_flags    = FL_RESP | FL_CRC;
          end
          PH_CMD55: begin
            st_nxt.phase = PH_ACMD41;
            has_result   = 1'b1;
            cmd_valid    = 1'b1;
            cmd_index    = ACMD_SD_OP_COND;
            cmd_arg      = op_cond_argument;
            cmd_flags    = FL_RESP;
          end
          PH_ACMD41: begin
            has_result = 1'b1;
            cmd_valid  = 1'b1;
            // busy bit clear: retry while attempts remain
            if (!resp_word0[31] && (try_inc < op_cond_tries)) begin
              st_nxt.try_count = try_inc;
              st_nxt.phase     = PH_CMD55;
              cmd_index        = CMD_APP_CMD;
              cmd_flags        = FL_RESP | FL_CRC;
            end else begin
              if (!resp_word0[31]) begin
                st_nxt.try_count      = try_inc;
                st_nxt.op_cond_failed = 1'b1;
              end
              st_nxt.phase = PH_CMD2;
              cmd_index    = CMD_ALL_SEND_CID;
              cmd_flags    = FL_RESP | FL_LONG | FL_CRC;
            end
          end
          PH_CMD2: begin
            st_nxt.phase = PH_CMD3;
            has_result   = 1'b1;
            cmd_valid    = 1'b1;
            cmd_index    = CMD_SEND_RCA;
            cmd_flags    = FL_RESP | FL_CRC;
          end
          PH_CMD3: begin
            st_nxt.card_address = resp_word0[31:16];
            st_nxt.phase        = PH_CMD9;
            has_result          = 1'b1;
            cmd_valid           = 1'b1;
            cmd_index           = CMD_SEND_CSD;
            cmd_arg             = {resp_word0[31:16], 16'd0};
            cmd_flags           = FL_RESP | FL_LONG | FL_CRC;
          end
          PH_CMD9: begin
            st_nxt.csd_version   = csd_version;
            st_nxt.card_capacity = csd_capacity;
            st_nxt.no_card       = st.no_card | csd_unknown;
            st_nxt.phase         = PH_CMD7;
            has_result           = 1'b1;
            cmd_valid            = 1'b1;
            cmd_index            = CMD_SELECT;
            cmd_arg              = rca_arg;
            cmd_flags            = FL_RESP | FL_CRC;
          end
          PH_CMD7: begin
            has_result = 1'b1;
            // block length only matters for byte addressed cards
            if (st.csd_version == CSD_V1) begin
              st_nxt.phase = PH_CMD16;
              cmd_valid    = 1'b1;
              cmd_index    = CMD_SET_BLKLEN;
              cmd_arg      = BLKLEN_ARG;
              cmd_flags    = FL_RESP | FL_CRC;
            end else begin
              st_nxt.phase = PH_READY;
            end
          end
          PH_CMD16: begin
            st_nxt.phase = PH_READY;
            has_result   = 1'b1;
          end
          PH_STATUS: begin
            has_result = 1'b1;
            if (card_ready) begin
              st_nxt.phase = PH_READY;
            end else begin
              cmd_valid = 1'b1;
              cmd_index = CMD_SEND_STATUS;
              cmd_arg   = rca_arg;
              cmd_flags = FL_RESP | FL_CRC;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    res.cmd_valid      = cmd_valid;
    res.cmd_index      = cmd_valid ? cmd_index : CMD_GO_IDLE;
    res.cmd_arg        = cmd_valid ? cmd_arg : 32'd0;
    res.cmd_flags      = cmd_valid ? cmd_flags : 10'd0;
    res.init_done      = (st_nxt.phase == PH_READY) || (st_nxt.phase == PH_WDATA) ||
                         (st_nxt.phase == PH_STATUS);
    res.capacity_kb    = st_nxt.card_capacity;
    res.high_capacity  = (st_nxt.csd_version != CSD_V1);
    res.no_card        = st_nxt.no_card;
    res.op_cond_failed = st_nxt.op_cond_failed;
  end

endmodule

`default_nettype wire

// ===== src/sdc_out_reg.sv =====
// sdc_out_reg: result register with valid/stall handshake
`default_nettype none

module sdc_out_reg (
  input  wire  logic             clk,
  input  wire  logic             rst_n,
  input  wire  logic             in_take,
  input  wire  logic             has_result,
  input  wire  sdc_pkg::result_t res,
  input  wire  logic             out_stall,
  output logic                   out_valid,
  output logic                   busy,
  output sdc_pkg::result_t       res_q
);
  import sdc_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  logic    load;
  result_t res_r;

  // the register can take a new result when empty or being drained this cycle
  assign busy      = valid_r && out_stall;
  assign load      = in_take && has_result;
  assign valid_nxt = busy ? 1'b1 : load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign res_q     = res_r;

endmodule

`default_nettype wire

// ===== src/sd_card_init_and_sector_sequencer_unit.sv =====
// sd_card_init_and_sector_sequencer_unit: sd card init and sector command sequencer, top level
//
//   channel   direction  handshake          payload
//   in_       input      in_valid/in_stall  kind, resp_word0..3, sector
//   out_      output     out_valid/out_stall command, status and card information
//   cfg_      input      cfg_valid/cfg_ready register index, write data
//
// one event per cycle while in_stall is low: the sequencer state updates at the accepting edge and the
// result, if any, sits in the result register from the next cycle on.
// the state step plus csd decode between state and result register sets the cycle.
// in_stall rises only while a result is held and out_stall is high.
// rst_n (synchronous) returns the sequence to idle and the registers to defaults.
`default_nettype none

module sd_card_init_and_sector_sequencer_unit (
  input  wire  logic                          clk,
  input  wire  logic                          rst_n,
  input  wire  logic                          in_valid,
  output logic                                in_stall,
  input  wire  logic [2:0]                    in_kind,
  input  wire  logic [31:0]                   in_resp_word0,
  input  wire  logic [31:0]                   in_resp_word1,
  input  wire  logic [31:0]                   in_resp_word2,
  input  wire  logic [31:0]                   in_resp_word3,
  input  wire  logic [31:0]                   in_sector,
  output logic                                out_valid,
  input  wire  logic                          out_stall,
  output logic [5:0]                          out_cmd_index,
  output logic [31:0]                         out_cmd_arg,
  output logic [9:0]                          out_cmd_flags,
  output logic                                out_cmd_valid,
  output logic                                out_init_done,
  output logic [31:0]                         out_capacity_kb,
  output logic                                out_high_capacity,
  output logic                                out_no_card,
  output logic                                out_op_cond_failed,
  input  wire  logic                          cfg_valid,
  output logic                                cfg_ready,
  input  wire  logic [sdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  logic [31:0]                   cfg_data
);
  import sdc_pkg::*;

  state_t      st_r;
  state_t      st_nxt;
  logic [7:0]  op_cond_tries_r;
  logic [31:0] op_cond_arg_r;
  logic        has_result;
  result_t     res;
  result_t     res_q;
  logic        busy;
  logic        in_take;

  assign in_stall  = busy;
  assign in_take   = in_valid && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_cond_tries_r <= OP_COND_TRIES_RST;
      op_cond_arg_r   <= OP_COND_ARG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OP_COND_TRIES: op_cond_tries_r <= cfg_data[7:0];
        CFG_OP_COND_ARG:   op_cond_arg_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (in_take) begin
      st_r <= st_nxt;
    end
  end

  sdc_step u_step (
    .st               (st_r),
    .op_cond_tries    (op_cond_tries_r),
    .op_cond_argument (op_cond_arg_r),
    .kind             (in_kind),
    .resp_word0       (in_resp_word0),
    .resp_word1       (in_resp_word1),
    .resp_word2       (in_resp_word2),
    .resp_word3       (in_resp_word3),
    .sector           (in_sector),
    .st_nxt           (st_nxt),
    .has_result       (has_result),
    .res              (res)
  );

  sdc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .has_result (has_result),
    .res        (res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .busy       (busy),
    .res_q      (res_q)
  );

  assign out_cmd_index      = res_q.cmd_index;
  assign out_cmd_arg        = res_q.cmd_arg;
  assign out_cmd_flags      = res_q.cmd_flags;
  assign out_cmd_valid      = res_q.cmd_valid;
  assign out_init_done      = res_q.init_done;
  assign out_capacity_kb    = res_q.capacity_kb;
  assign out_high_capacity  = res_q.high_capacity;
  assign out_no_card        = res_q.no_card;
  assign out_op_cond_failed = res_q.op_cond_failed;

endmodule

`default_nettype wire

// ===== src/sdc_checker.sv =====
// sdc_checker: port-level assertions for the sd card sequencer and their bind
`default_nettype none

module sdc_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic [2:0]                    in_kind,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [5:0]                    out_cmd_index,
  input  wire logic [31:0]                   out_cmd_arg,
  input  wire logic [9:0]                    out_cmd_flags,
  input  wire logic                          out_cmd_valid,
  input  wire logic                          out_init_done
);
  import sdc_pkg::*;

  // a held result keeps its command
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cmd_index) &&
                               $stable(out_cmd_arg) && $stable(out_cmd_flags))
    else $error("result changed while stalled");

  // a start transaction yields go-idle in the next cycle, sequence not done
  a_start_cmd0: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == KIND_START |=>
      out_valid && out_cmd_valid && out_cmd_index == CMD_GO_IDLE && !out_init_done)
    else $error("start did not issue go-idle");

  // status results carry an empty command
  a_status_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cmd_valid |->
      out_cmd_index == CMD_GO_IDLE && out_cmd_arg == 32'd0 && out_cmd_flags == 10'd0)
    else $error("status result with command fields");

  // sector transfers only once initialisation has finished
  a_xfer_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmd_valid &&
    (out_cmd_index == CMD_READ_SINGLE || out_cmd_index == CMD_WRITE_SINGLE) |->
      out_init_done)
    else $error("sector command before init done");

endmodule

bind sd_card_init_and_sector_sequencer_unit sdc_checker u_sdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_kind       (in_kind),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_cmd_index (out_cmd_index),
  .out_cmd_arg   (out_cmd_arg),
  .out_cmd_flags (out_cmd_flags),
  .out_cmd_valid (out_cmd_valid),
  .out_init_done (out_init_done)
);

`default_nettype wire

// ===== bench/sdc_seq_scoreboard_pkg.sv =====
// command sequencer predictor and scoreboard for the sd card sequencer bench
package sdc_seq_scoreboard_pkg;
  import sdc_pkg::*;

  class sdc_seq_scoreboard;
    // register copies
    logic [7:0]  tries_limit;
    logic [31:0] op_cond_word;

    // card and sequence state
    phase_t      phase;
    logic [7:0]  try_count;
    logic [15:0] rca;
    logic [1:0]  csd_ver;
    logic [31:0] cap_kb;
    logic        op_failed;
    logic        card_missing;

    result_t     cmd_results_due[$];
    int          fails;

    function new();
      tries_limit  = OP_COND_TRIES_RST;
      op_cond_word = OP_COND_ARG_RST;
      phase        = PH_IDLE;
      try_count    = '0;
      rca          = '0;
      csd_ver      = CSD_V1;
      cap_kb       = '0;
      op_failed    = 1'b0;
      card_missing = 1'b0;
      fails        = 0;
    endfunction

    function int pending();
      return cmd_results_due.size();
    endfunction

    function void write_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == CFG_OP_COND_TRIES) tries_limit = data[7:0];
      else op_cond_word = data;
    endfunction

    // result fields carry the state as it stands after the update
    function void push_result(bit is_cmd, logic [5:0] idx, logic [31:0] arg, logic [9:0] flags);
      result_t r;
      r.cmd_index      = is_cmd ? idx : '0;
      r.cmd_arg        = is_cmd ? arg : '0;
      r.cmd_flags      = is_cmd ? flags : '0;
      r.cmd_valid      = is_cmd;
      r.init_done      = (phase == PH_READY || phase == PH_WDATA || phase == PH_STATUS);
      r.capacity_kb    = cap_kb;
      r.high_capacity  = (csd_ver != CSD_V1);
      r.no_card        = card_missing;
      r.op_cond_failed = op_failed;
      cmd_results_due.push_back(r);
    endfunction

    function void decode_csd(logic [31:0] w1, logic [31:0] w2, logic [31:0] w3);
      logic [63:0] bytes;
      logic [11:0] size_v1;
      logic [21:0] size_v2;
      int unsigned sh;
      csd_ver = w3[31:30];
      if (csd_ver == CSD_V1) begin
        size_v1 = {w2[9:0], w1[31:30]};
        sh      = w1[17:15] + 2 + w2[19:16];
        bytes   = (64'(size_v1) + 64'd1) << sh;
        cap_kb  = bytes[41:10];
      end else if (csd_ver == CSD_V2) begin
        size_v2 = {w2[5:0], w1[31:16]};
        bytes   = (64'(size_v2) + 64'd1) * 64'd512;
        cap_kb  = bytes[31:0];
      end else begin
        cap_kb       = '0;
        card_missing = 1'b1;
      end
    endfunction

    function void predict_event(logic [2:0] kind, logic [31:0] w0, logic [31:0] w1,
                                logic [31:0] w2, logic [31:0] w3, logic [31:0] sec);
      logic [31:0] rca_arg;
      logic [31:0] addr;
      rca_arg = {rca, 16'h0000};
      addr    = (csd_ver == CSD_V1) ? {sec[22:0], 9'd0} : sec;
      case (kind)
        KIND_START: begin
          try_count    = '0;
          rca          = '0;
          csd_ver      = CSD_V1;
          cap_kb       = '0;
          op_failed    = 1'b0;
          card_missing = 1'b0;
          phase        = PH_CMD0;
          push_result(1'b1, CMD_GO_IDLE, 32'd0, FL_INIT | FL_CRC);
        end
        KIND_READ: begin
          if (phase == PH_READY)
            push_result(1'b1, CMD_READ_SINGLE, addr, FL_RESP | FL_CRC | FL_DATA | FL_WAIT);
        end
        KIND_WRITE: begin
          if (phase == PH_READY) begin
            phase = PH_WDATA;
            push_result(1'b1, CMD_WRITE_SINGLE, addr,
                        FL_RESP | FL_CRC | FL_DATA | FL_WAIT | FL_WRITE);
          end
        end
        KIND_DATA_DONE: begin
          if (phase == PH_WDATA) begin
            phase = PH_STATUS;
            push_result(1'b1, CMD_SEND_STATUS, rca_arg, FL_RESP | FL_CRC);
          end
        end
        KIND_RESP: begin
          case (phase)
            PH_CMD0: begin
              phase = PH_CMD8;
              push_result(1'b1, CMD_SEND_IF_COND, IF_COND_ARG, FL_RESP | FL_CRC);
            end
            PH_CMD8: begin
              phase = PH_CMD55;
              push_result(1'b1, CMD_APP_CMD, 32'd0, FL_RESP | FL_CRC);
            end
            PH_CMD55: begin
              phase = PH_ACMD41;
              push_result(1'b1, ACMD_SD_OP_COND, op_cond_word, FL_RESP);
            end
            PH_ACMD41: begin
              if (!w0[31]) try_count = try_count + 8'd1;
              // busy card with tries left goes round cmd55 again
              if (!w0[31] && try_count < tries_limit) begin
                phase = PH_CMD55;
                push_result(1'b1, CMD_APP_CMD, 32'd0, FL_RESP | FL_CRC);
              end else begin
                if (!w0[31]) op_failed = 1'b1;
                phase = PH_CMD2;
                push_result(1'b1, CMD_ALL_SEND_CID, 32'd0, FL_RESP | FL_LONG | FL_CRC);
              end
            end
            PH_CMD2: begin
              phase = PH_CMD3;
              push_result(1'b1, CMD_SEND_RCA, 32'd0, FL_RESP | FL_CRC);
            end
            PH_CMD3: begin
              rca   = w0[31:16];
              phase = PH_CMD9;
              push_result(1'b1, CMD_SEND_CSD, {w0[31:16], 16'h0000},
                          FL_RESP | FL_LONG | FL_CRC);
            end
            PH_CMD9: begin
              decode_csd(w1, w2, w3);
              phase = PH_CMD7;
              push_result(1'b1, CMD_SELECT, rca_arg, FL_RESP | FL_CRC);
            end
            PH_CMD7: begin
              if (csd_ver == CSD_V1) begin
                phase = PH_CMD16;
                push_result(1'b1, CMD_SET_BLKLEN, BLKLEN_ARG, FL_RESP | FL_CRC);
              end else begin
                phase = PH_READY;
                push_result(1'b0, '0, '0, '0);
              end
            end
            PH_CMD16: begin
              phase = PH_READY;
              push_result(1'b0, '0, '0, '0);
            end
            PH_STATUS: begin
              if (w0[8] && w0[12:9] != CARD_STATE_PRG) begin
                phase = PH_READY;
                push_result(1'b0, '0, '0, '0);
              end else begin
                push_result(1'b1, CMD_SEND_STATUS, rca_arg, FL_RESP | FL_CRC);
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        fails++;
        if (fails <= 10)
          $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (cmd_results_due.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: expected none, got %h", got);
        return;
      end
      want = cmd_results_due.pop_front();
      compare_field("cmd_index", 32'(want.cmd_index), 32'(got.cmd_index));
      compare_field("cmd_arg", want.cmd_arg, got.cmd_arg);
      compare_field("cmd_flags", 32'(want.cmd_flags), 32'(got.cmd_flags));
      compare_field("cmd_valid", 32'(want.cmd_valid), 32'(got.cmd_valid));
      compare_field("init_done", 32'(want.init_done), 32'(got.init_done));
      compare_field("capacity_kb", want.capacity_kb, got.capacity_kb);
      compare_field("high_capacity", 32'(want.high_capacity), 32'(got.high_capacity));
      compare_field("no_card", 32'(want.no_card), 32'(got.no_card));
      compare_field("op_cond_failed", 32'(want.op_cond_failed), 32'(got.op_cond_failed));
    endfunction
  endclass

endpackage

// ===== bench/sd_card_init_and_sector_sequencer_unit_test.sv =====
// testbench top for the sd card init and sector command sequencer
module sd_card_init_and_sector_sequencer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sdc_pkg::*;
  import sdc_seq_scoreboard_pkg::*;

  localparam int          ITEMS          = 800;
  localparam int          TAIL_ITEMS     = 80;
  localparam int          HOLD_OFF       = 60;
  localparam int          CYCLE_LIMIT    = 400000;
  localparam logic [2:0]  KIND_RESERVED  = 3'd7;
  localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           in_kind = KIND_START;
  logic [31:0]          in_resp_word0 = '0;
  logic [31:0]          in_resp_word1 = '0;
  logic [31:0]          in_resp_word2 = '0;
  logic [31:0]          in_resp_word3 = '0;
  logic [31:0]          in_sector = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [5:0]           out_cmd_index;
  logic [31:0]          out_cmd_arg;
  logic [9:0]           out_cmd_flags;
  logic                 out_cmd_valid;
  logic                 out_init_done;
  logic [31:0]          out_capacity_kb;
  logic                 out_high_capacity;
  logic                 out_no_card;
  logic                 out_op_cond_failed;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_OP_COND_TRIES;
  logic [31:0]          cfg_data = '0;

  sdc_seq_scoreboard sb = new();

  bit tail;
  bit hold_off_req;
  bit holding;
  int cycles;
  int sent;

  sd_card_init_and_sector_sequencer_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_resp_word0      (in_resp_word0),
    .in_resp_word1      (in_resp_word1),
    .in_resp_word2      (in_resp_word2),
    .in_resp_word3      (in_resp_word3),
    .in_sector          (in_sector),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cmd_index      (out_cmd_index),
    .out_cmd_arg        (out_cmd_arg),
    .out_cmd_flags      (out_cmd_flags),
    .out_cmd_valid      (out_cmd_valid),
    .out_init_done      (out_init_done),
    .out_capacity_kb    (out_capacity_kb),
    .out_high_capacity  (out_high_capacity),
    .out_no_card        (out_no_card),
    .out_op_cond_failed (out_op_cond_failed),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: compare every accepted transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_cmd_index, out_cmd_arg, out_cmd_flags, out_cmd_valid,
                        out_init_done, out_capacity_kb, out_high_capacity,
                        out_no_card, out_op_cond_failed});
  end

  // receiver stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF - 1) @(posedge clk);
        holding = 1'b0;
      end else if (tail || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 7)) @(posedge clk);
      end
    end
  end

  task automatic send_event(input logic [2:0] kind, input logic [31:0] w0,
                            input logic [31:0] w1, input logic [31:0] w2,
                            input logic [31:0] w3, input logic [31:0] sec);
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_resp_word0 <= w0;
    in_resp_word1 <= w1;
    in_resp_word2 <= w2;
    in_resp_word3 <= w3;
    in_sector     <= sec;
    do @(posedge clk); while (in_stall);
    sb.predict_event(kind, w0, w1, w2, w3, sec);
    sent++;
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk);
  endtask

  // wait for every outstanding command result, then idle with in_valid low
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_config(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly well-formed card traffic driven by the predicted phase, some noise
  task automatic offer_next();
    logic [2:0]  k;
    logic [31:0] w0, w1, w2, w3, sec;
    int          pick, v;
    k    = KIND_RESP;
    w0   = $urandom;
    w1   = $urandom;
    w2   = $urandom;
    w3   = $urandom;
    sec  = $urandom;
    pick = $urandom_range(0, 99);
    v    = $urandom_range(0, 9);
    if (pick < 8) begin
      k = 3'($urandom_range(0, 7));
    end else begin
      case (sb.phase)
        PH_IDLE: k = KIND_START;
        PH_READY: begin
          if (pick < 14) k = KIND_START;
          else if (pick < 22) k = (v < 5) ? KIND_RESP : KIND_DATA_DONE;
          else if (pick < 61) k = KIND_READ;
          else k = KIND_WRITE;
        end
        PH_WDATA: begin
          if (pick < 18) k = (v < 5) ? KIND_READ : KIND_RESP;
          else k = KIND_DATA_DONE;
        end
        PH_ACMD41: w0[31] = ($urandom_range(0, 2) == 0);
        PH_CMD9: begin
          if (v < 5) w3[31:30] = CSD_V1;
          else if (v < 9) w3[31:30] = CSD_V2;
          else w3[31:30] = 2'($urandom_range(2, 3));
        end
        PH_STATUS: begin
          if (v < 5) begin
            w0[8] = 1'b1;
            do w0[12:9] = 4'($urandom); while (w0[12:9] == CARD_STATE_PRG);
          end else if (v < 8) begin
            w0[8] = 1'b0;
          end else begin
            w0[8]    = 1'b1;
            w0[12:9] = CARD_STATE_PRG;
          end
        end
        default: ;
      endcase
    end
    send_event(k, w0, w1, w2, w3, sec);
  endtask

  initial begin
    int  next_cfg_at;
    int  setting_no;
    bit  pressed;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: strays first, then a full init with a failed op-cond and a write
    write_reg(CFG_OP_COND_TRIES, 32'hFFFF_FF02);
    write_reg(CFG_OP_COND_ARG, ALL_ONES);
    send_event(KIND_RESP, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_event(KIND_READ, '0, '0, '0, '0, 32'd5);
    send_event(KIND_RESERVED, ALL_ONES, '0, ALL_ONES, '0, ALL_ONES);
    send_event(KIND_DATA_DONE, '0, '0, '0, '0, '0);
    send_event(KIND_START, '0, '0, '0, '0, '0);
    send_event(KIND_RESP, '0, '0, '0, '0, '0);
    send_event(KIND_RESP, '0, '0, '0, '0, '0);
    send_event(KIND_RESP, '0, '0, '0, '0, '0);
    send_event(KIND_RESP, 32'h7FFF_FFFF, '0, '0, '0, '0);
    send_event(KIND_RESP, '0, '0, '0, '0, '0);
    send_event(KIND_RESP, '0, '0, '0, '0, '0);
    send_event(KIND_RESP, '0, '0, '0, '0, '0);
    send_event(KIND_RESP, 32'hFFFF_0000, '0, '0, '0, '0);
    // largest standard-capacity csd
    send_event(KIND_RESP, '0, ALL_ONES, 32'h000F_03FF, 32'h3FFF_FFFF, '0);
    send_event(KIND_RESP, '0, '0, '0, '0, '0);
    send_event(KIND_RESP, '0, '0, '0, '0, '0);
    // byte address wraps past 32 bits
    send_event(KIND_READ, '0, '0, '0, '0, ALL_ONES);
    send_event(KIND_WRITE, '0, '0, '0, '0, '0);
    send_event(KIND_READ, '0, '0, '0, '0, 32'd1);
    send_event(KIND_DATA_DONE, '0, '0, '0, '0, '0);
    send_event(KIND_RESP, 32'h0000_0100 | {19'd0, CARD_STATE_PRG, 9'd0}, '0, '0, '0, '0);
    send_event(KIND_RESP, 32'h0000_0100, '0, '0, '0, '0);
    send_event(KIND_START, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    settle();
    write_reg(CFG_OP_COND_TRIES, 32'd0);
    write_reg(CFG_OP_COND_ARG, 32'd0);

    next_cfg_at = sent + 150;
    setting_no  = 0;
    pressed     = 1'b0;
    while (sent < ITEMS) begin
      tail = (sent >= ITEMS - TAIL_ITEMS);
      if (!tail && sent >= next_cfg_at) begin
        settle();
        case (setting_no % 5)
          0: begin
            write_reg(CFG_OP_COND_TRIES, 32'd1);
            write_reg(CFG_OP_COND_ARG, ALL_ONES);
          end
          1: begin
            write_reg(CFG_OP_COND_TRIES, 32'd255);
            write_reg(CFG_OP_COND_ARG, $urandom);
          end
          2: begin
            write_reg(CFG_OP_COND_TRIES, {24'($urandom_range(0, 16777215)), 8'd3});
            write_reg(CFG_OP_COND_ARG, OP_COND_ARG_RST);
          end
          3: begin
            write_reg(CFG_OP_COND_TRIES, $urandom);
            write_reg(CFG_OP_COND_ARG, 32'd0);
          end
          default: begin
            write_reg(CFG_OP_COND_TRIES, $urandom_range(0, 12));
            write_reg(CFG_OP_COND_ARG, $urandom);
          end
        endcase
        setting_no++;
        next_cfg_at += 150;
      end
      // long receiver hold-off while the sender keeps offering transactions
      if (!pressed && sent >= 300) begin
        hold_off_req = 1'b1;
        pressed      = 1'b1;
      end
      offer_next();
      if (!tail && !holding && $urandom_range(0, 3) == 0) idle_gap();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
